// ----- sv/chained_hash_table_defines.svh -----
// Assertion macros for the chained hash table.
// Expects clk and rst_n in the scope of the including module.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CHT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant, checked outside reset
`define CHT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- sv/cht_pkg.sv -----
// Shared constants, codes and port structs for the chained hash table.
// No dependencies.
`default_nettype none

package cht_pkg;

  localparam int NUM_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 8;
  localparam int KEY_W        = 31;
  localparam int CFG_W        = 7;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int BUCKET_W     = $clog2(NUM_BUCKETS);
  localparam int POS_W        = $clog2(BUCKET_DEPTH);
  localparam int FILL_W       = POS_W + 1;
  localparam int ADDR_W       = BUCKET_W + POS_W;
  localparam int DIV_CNT_W    = $clog2(KEY_W);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_DEL_FAIL  = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FILL,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [BUCKET_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  data;
  } key_wr_t;

  typedef struct packed {
    logic                en;
    logic [BUCKET_W-1:0] addr;
    logic [FILL_W-1:0]   data;
  } fill_wr_t;

endpackage

`default_nettype wire

// ----- sv/chained_hash_table.sv -----
// Chained hash table top level: request sequencer, output register and assertions.
// Depends on cht_pkg, cht_divider, cht_key_ram, cht_fill_ram and the defines header.
//
// One request is worked at a time. After acceptance the bucket (key mod bucket_count,
// with the count clamped to 1..64) comes from a bit-serial remainder unit, then the
// bucket fill is read, and the bucket is then walked through the single read port of
// the key memory, one read per entry: insert moves fill entries back, delete scans up
// to the match and closes the gap, search scans the whole bucket. A request is held
// while the result side holds out_stall. The last result may wait in the output
// register while the next request is accepted. Fill counts read as zero after reset;
// no clearing pass is needed. func 3 is accepted and produces no result.

`default_nettype none
`include "chained_hash_table_defines.svh"

module chained_hash_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cht_pkg::CFG_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cht_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [cht_pkg::KEY_W-1:0]     in_key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [cht_pkg::STATUS_W-1:0]       out_status,
  output logic [cht_pkg::BUCKET_W-1:0]       out_bucket,
  output logic [cht_pkg::POS_W-1:0]          out_position,
  output logic                               out_last
);
  import cht_pkg::*;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    bucket_count_r;
  logic [CFG_W-1:0]    modulus;
  func_t               func_r;
  logic [KEY_W-1:0]    key_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   ptr_r;
  logic [FILL_W-1:0]   ptr_inc, ptr_dec;
  status_t             res_status_r;
  logic [POS_W-1:0]    res_pos_r;
  logic                pend_valid_r;
  logic [POS_W-1:0]    pend_pos_r;

  logic                in_accept;
  logic                out_can;
  logic                key_match;
  logic                scan_hold;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  key_wr_t             key_wr;
  fill_wr_t            fill_wr;
  logic                key_rd_en;
  logic [ADDR_W-1:0]   key_rd_addr;
  logic [KEY_W-1:0]    key_rd_data;
  logic                fill_rd_en;
  logic [BUCKET_W-1:0] fill_rd_addr;
  logic [FILL_W-1:0]   fill_rd_data;

  logic                push;
  status_t             push_status;
  logic [POS_W-1:0]    push_pos;
  logic                push_last;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [BUCKET_W-1:0] out_bucket_r;
  logic [POS_W-1:0]    out_pos_r;
  logic                out_last_r;

  cht_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cht_key_ram u_keys (
    .clk     (clk),
    .wr      (key_wr),
    .rd_en   (key_rd_en),
    .rd_addr (key_rd_addr),
    .rd_data (key_rd_data)
  );

  cht_fill_ram u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fill_wr),
    .rd_en   (fill_rd_en),
    .rd_addr (fill_rd_addr),
    .rd_data (fill_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_can   = !out_valid_r || !out_stall;
  assign ptr_inc   = ptr_r + 1'b1;
  assign ptr_dec   = ptr_r - 1'b1;
  assign key_match = (key_rd_data == key_r);
  // an earlier match must go out before a new one replaces it
  assign scan_hold = (func_r == FUNC_SEARCH) && key_match && pend_valid_r && !out_can;

  always_comb begin
    if (bucket_count_r == '0) begin
      modulus = CFG_W'(1);
    end else if (bucket_count_r > CFG_W'(NUM_BUCKETS)) begin
      modulus = CFG_W'(NUM_BUCKETS);
    end else begin
      modulus = bucket_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= CFG_W'(NUM_BUCKETS);
    end else if (cfg_wr_en) begin
      bucket_count_r <= cfg_wr_data;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept && (func_t'(in_func) != FUNC_NONE)) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        if (func_r == FUNC_INSERT) begin
          state_nxt = (fill_rd_data == FILL_W'(BUCKET_DEPTH)) ? S_EMIT : S_SHIFT_RD;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = (ptr_r == '0) ? S_EMIT : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_SCAN_RD:  state_nxt = (ptr_r == fill_r) ? S_EMIT : S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (func_r == FUNC_DELETE && key_match) begin
          state_nxt = S_DEL_RD;
        end else if (!scan_hold) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_DEL_RD:   state_nxt = (ptr_inc == fill_r) ? S_EMIT : S_DEL_WR;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_EMIT: begin
        if (out_can) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // memory requests and result pushes
  always_comb begin
    div_req.start    = in_accept && (func_t'(in_func) != FUNC_NONE);
    div_req.dividend = in_key;
    div_req.divisor  = modulus;
    fill_rd_en       = 1'b0;
    fill_rd_addr     = div_rsp.rem;
    fill_wr.en       = 1'b0;
    fill_wr.addr     = bucket_r;
    fill_wr.data     = fill_r;
    key_rd_en        = 1'b0;
    key_rd_addr      = {bucket_r, ptr_r[POS_W-1:0]};
    key_wr.en        = 1'b0;
    key_wr.addr      = {bucket_r, ptr_r[POS_W-1:0]};
    key_wr.data      = key_rd_data;
    push             = 1'b0;
    push_status      = res_status_r;
    push_pos         = res_pos_r;
    push_last        = 1'b1;
    unique case (state_r)
      S_DIV: begin
        fill_rd_en = div_rsp.done;
      end
      S_SHIFT_RD: begin
        if (ptr_r == '0) begin
          key_wr.en    = 1'b1;
          key_wr.data  = key_r;
          fill_wr.en   = 1'b1;
          fill_wr.data = fill_r + 1'b1;
        end else begin
          key_rd_en   = 1'b1;
          key_rd_addr = {bucket_r, ptr_dec[POS_W-1:0]};
        end
      end
      S_SHIFT_WR: begin
        key_wr.en = 1'b1;
      end
      S_SCAN_RD: begin
        key_rd_en = (ptr_r != fill_r);
      end
      S_SCAN_CHK: begin
        if (func_r == FUNC_SEARCH && key_match && pend_valid_r && out_can) begin
          push        = 1'b1;
          push_status = ST_FOUND;
          push_pos    = pend_pos_r;
          push_last   = 1'b0;
        end
      end
      S_DEL_RD: begin
        if (ptr_inc == fill_r) begin
          fill_wr.en   = 1'b1;
          fill_wr.data = fill_r - 1'b1;
        end else begin
          key_rd_en   = 1'b1;
          key_rd_addr = {bucket_r, ptr_inc[POS_W-1:0]};
        end
      end
      S_DEL_WR: begin
        key_wr.en = 1'b1;
      end
      S_EMIT: begin
        push = out_can;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pend_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FILL) begin
        pend_valid_r <= 1'b0;
      end else if (state_r == S_SCAN_CHK && func_r == FUNC_SEARCH && key_match
                   && !scan_hold) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          func_r <= func_t'(in_func);
          key_r  <= in_key;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          bucket_r <= div_rsp.rem;
        end
      end
      S_FILL: begin
        fill_r       <= fill_rd_data;
        res_status_r <= ST_FULL;
        res_pos_r    <= '0;
        ptr_r        <= (func_r == FUNC_INSERT) ? fill_rd_data : '0;
      end
      S_SHIFT_RD: begin
        if (ptr_r == '0) begin
          res_status_r <= ST_INSERTED;
          res_pos_r    <= '0;
        end
      end
      S_SHIFT_WR: begin
        ptr_r <= ptr_dec;
      end
      S_SCAN_RD: begin
        if (ptr_r == fill_r) begin
          priority if (func_r == FUNC_DELETE) begin
            res_status_r <= ST_DEL_FAIL;
            res_pos_r    <= '0;
          end else if (pend_valid_r) begin
            res_status_r <= ST_FOUND;
            res_pos_r    <= pend_pos_r;
          end else begin
            res_status_r <= ST_NOT_FOUND;
            res_pos_r    <= '0;
          end
        end
      end
      S_SCAN_CHK: begin
        if (func_r == FUNC_DELETE && key_match) begin
          res_status_r <= ST_DELETED;
          res_pos_r    <= ptr_r[POS_W-1:0];
        end else if (!scan_hold) begin
          if (key_match) begin
            pend_pos_r <= ptr_r[POS_W-1:0];
          end
          ptr_r <= ptr_inc;
        end
      end
      S_DEL_WR: begin
        ptr_r <= ptr_inc;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_status_r <= push_status;
      out_bucket_r <= bucket_r;
      out_pos_r    <= push_pos;
      out_last_r   <= push_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_bucket   = out_bucket_r;
  assign out_position = out_pos_r;
  assign out_last     = out_last_r;

  `CHT_ASSERT_IMP(a_push_no_overwrite, push, out_can, "result pushed over a waiting result")
  `CHT_ASSERT_IMP(a_fill_bound, fill_wr.en, fill_wr.data <= FILL_W'(BUCKET_DEPTH), "fill overflow")
  `CHT_ASSERT_ALWAYS(a_key_port_excl, !(key_wr.en && key_rd_en), "key read and write overlap")
  `CHT_ASSERT_IMP(a_div_done_state, div_rsp.done, state_r == S_DIV, "remainder outside divide")

endmodule

`default_nettype wire

// ----- sv/cht_divider.sv -----
// Bit-serial restoring remainder unit: key mod bucket count, one key bit per cycle.
// Depends on cht_pkg.
`default_nettype none

module cht_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cht_pkg::div_req_t req,
  output cht_pkg::div_rsp_t      rsp
);
  import cht_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0]     dvd_r;
  logic [CFG_W-1:0]     dvs_r;
  logic [CFG_W-1:0]     rem_r;
  logic [CFG_W-1:0]     trial;

  // remainder stays below the divisor (<= 64), so the top bit is free to shift into
  assign trial = {rem_r[CFG_W-2:0], dvd_r[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(KEY_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[KEY_W-2:0], 1'b0};
      rem_r <= (trial >= dvs_r) ? (trial - dvs_r) : trial;
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[BUCKET_W-1:0];

endmodule

`default_nettype wire

// ----- sv/cht_key_ram.sv -----
// Key store: one entry per bucket slot, one write and one registered read port.
// Contents are undefined until written. Depends on cht_pkg.
`default_nettype none

module cht_key_ram (
  input  wire logic                      clk,
  input  wire cht_pkg::key_wr_t          wr,
  input  wire logic                      rd_en,
  input  wire logic [cht_pkg::ADDR_W-1:0] rd_addr,
  output logic [cht_pkg::KEY_W-1:0]      rd_data
);
  import cht_pkg::*;

  logic [KEY_W-1:0] mem [NUM_BUCKETS*BUCKET_DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/cht_fill_ram.sv -----
// Per-bucket fill counts with a registered read; a valid bit per bucket
// makes unwritten counts read as zero after reset. Depends on cht_pkg.
`default_nettype none

module cht_fill_ram (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cht_pkg::fill_wr_t           wr,
  input  wire logic                        rd_en,
  input  wire logic [cht_pkg::BUCKET_W-1:0] rd_addr,
  output logic [cht_pkg::FILL_W-1:0]       rd_data
);
  import cht_pkg::*;

  logic [FILL_W-1:0]      mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid_r;
  logic [FILL_W-1:0]      rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
